// ----- rtl/nced_pkg.sv -----
// ----------------------------------------------------------------------------
// nced_pkg - shared types, constants and helpers for the entity decoder
// Character codes, parse modes, sequencer states, the request link between
// the sequencer and the output stage, and UTF-8 byte helpers.
// ----------------------------------------------------------------------------
package nced_pkg;

  // longest digit run a reference may hold
  localparam int MAX_DIGITS = 16;

  localparam int HELD_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  // reference text index: '&', '#', optional 'x', then the digits
  localparam int REF_IDX_W  = $clog2(MAX_DIGITS + 3);

  localparam int CODE_W = 21;
  localparam int SUM_W  = CODE_W + 4;

  localparam logic [CODE_W-1:0] CODE_MAX  = 21'h10FFFF;
  localparam logic [CODE_W-1:0] CODE_CAP  = 21'h110000;
  localparam logic [CODE_W-1:0] CODE_REPL = 21'h00FFFD;

  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // register indexes on the config port (paddr[2])
  localparam logic REG_ENTITY = 1'b0;
  localparam logic REG_ESCAPE = 1'b1;

  typedef enum logic [2:0] {
    M_IDLE,
    M_AMP,
    M_HASH,
    M_DIGITS,
    M_ESC
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HANDLE,
    S_REF,
    S_UTF,
    S_SCAN,
    S_POST,
    S_DONE
  } seq_t;

  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       finish;
  } emit_req_t;

  typedef struct packed {
    logic push_ok;
    logic finish_ok;
  } emit_sts_t;

  // {valid, value} of a hex-style digit; A-F also count in decimal mode
  function automatic logic [4:0] digit_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
      return {1'b1, v[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
      return {1'b1, v[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
      return {1'b1, v[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // index of the last UTF-8 byte (byte count minus one)
  function automatic logic [1:0] utf8_last(input logic [CODE_W-1:0] cp);
    if (cp < 21'h000080) begin
      return 2'd0;
    end else if (cp < 21'h000800) begin
      return 2'd1;
    end else if (cp < 21'h010000) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

  // byte k of the UTF-8 encoding whose last index is n1
  function automatic logic [7:0] utf8_byte(input logic [CODE_W-1:0] cp,
                                           input logic [1:0]        n1,
                                           input logic [1:0]        k);
    logic [1:0] left;
    logic [7:0] r;
    left = n1 - k;
    if (k == 2'd0) begin
      unique case (n1)
        2'd0: r = {1'b0, cp[6:0]};
        2'd1: r = {3'b110, cp[10:6]};
        2'd2: r = {4'b1110, cp[15:12]};
        2'd3: r = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (left)
        2'd0:    r = {2'b10, cp[5:0]};
        2'd1:    r = {2'b10, cp[11:6]};
        default: r = {2'b10, cp[17:12]};
      endcase
    end
    return r;
  endfunction

endpackage

// ----- rtl/numeric_entity_and_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// numeric_entity_and_escape_decoder - numeric reference and hex escape decoder
// Passes text bytes through, turns "&#n;" / "&#xh;" into UTF-8 and a backslash
// with one or two hex digits into one raw byte.
// ----------------------------------------------------------------------------
// one request at a time: the sequencer takes a new byte only back in idle, after it
//   has sent every output byte of the last one; a full output stage stalls it
// output: a byte passes the sequencer, then the lookahead hold register, then the
//   output register before it shows on m_tvalid
// reset: rst (sync, high) returns to plain text, empties the output stage and
//   sets both enables to 1
// ----------------------------------------------------------------------------
module numeric_entity_and_escape_decoder
  import nced_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_text
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // run_last
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic      entity_enable;
  logic      escape_enable;
  logic      cfg_wr;
  emit_req_t emit_req;
  emit_sts_t emit_sts;

  // config registers, one per word; low address bits ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entity_enable <= 1'b1;
      escape_enable <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ENTITY: entity_enable <= pwdata[0];
        REG_ESCAPE: escape_enable <= pwdata[0];
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[2])
      REG_ENTITY: prdata = {31'b0, entity_enable};
      REG_ESCAPE: prdata = {31'b0, escape_enable};
    endcase
  end

  // parse state machine and byte sequencer
  nced_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_eot   (s_tlast),
    .ent_en   (entity_enable),
    .esc_en   (escape_enable),
    .req      (emit_req),
    .sts      (emit_sts)
  );

  // lookahead stage marks the last byte of each request
  nced_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req       (emit_req),
    .sts       (emit_sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ----- rtl/nced_acc.sv -----
// ----------------------------------------------------------------------------
// nced_acc - shared digit accumulate unit
// One shift-add step: acc * 16 + digit or acc * 10 + digit.
// ----------------------------------------------------------------------------
module nced_acc
  import nced_pkg::*;
(
  input  logic [CODE_W-1:0] acc,
  input  logic [3:0]        digit,
  input  logic              hex,
  output logic [SUM_W-1:0] sum
);

  logic [SUM_W-1:0] times_ten;

  // x10 as x8 + x2
  assign times_ten = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + SUM_W'(digit);
  assign sum       = hex ? {acc, digit} : times_ten;

endmodule

// ----- rtl/nced_emit.sv -----
// ----------------------------------------------------------------------------
// nced_emit - output staging with one byte of lookahead
// Holds the newest byte back so the last byte of a request gets tlast.
// ----------------------------------------------------------------------------
module nced_emit
  import nced_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  emit_req_t req,
  output emit_sts_t sts,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       out_free;
  logic       move;

  assign out_free      = !out_valid || out_ready;
  assign sts.push_ok   = !hold_valid || out_free;
  assign sts.finish_ok = !hold_valid || out_free;
  assign move          = hold_valid && out_free && (req.push || req.finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (req.push && sts.push_ok) begin
        hold_valid <= 1'b1;
      end else if (req.finish && sts.finish_ok) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte <= hold_byte;
      out_last <= req.finish;
    end
    if (req.push && sts.push_ok) begin
      hold_byte <= req.data;
    end
  end

endmodule

// ----- rtl/nced_ctrl.sv -----
// ----------------------------------------------------------------------------
// nced_ctrl - parse state and byte sequencer
// Steps through handle, rescan and flush of one request, one byte a cycle while the output stage takes them.
// ----------------------------------------------------------------------------
module nced_ctrl
  import nced_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eot,
  input  logic       ent_en,
  input  logic       esc_en,
  output emit_req_t  req,
  input  emit_sts_t  sts
);

  seq_t  seq, seq_next;
  mode_t mode, mode_next;
  logic                 hex, hex_next;
  logic [CODE_W-1:0]    acc, acc_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic                 esc_one, esc_one_next;
  logic                 rescan, rescan_next;
  logic [REF_IDX_W-1:0] idx, idx_next;
  logic [7:0]           cur_byte, cur_byte_next;
  logic                 cur_eot, cur_eot_next;
  logic [7:0]           held [MAX_DIGITS];
  logic                 held_we;

  logic                 accept;
  logic                 stall;
  logic [4:0]           dig;
  logic                 dig_ok;
  logic [SUM_W-1:0]     sum;
  logic                 in_esc;
  logic [CODE_W-1:0]    ent_acc;
  logic [7:0]           esc_val;
  logic [CODE_W-1:0]    cp;
  logic [1:0]           utf_n1;
  logic                 utf_last_byte;
  logic [REF_IDX_W-1:0] ref_len_m1;
  logic                 ref_last_byte;
  logic [REF_IDX_W-1:0] held_rd;
  logic [7:0]           ref_byte;
  logic                 x_start;
  logic                 dig_take;
  logic                 semi_end;
  seq_t                 after;

  assign in_ready = (seq == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign dig    = digit_value(cur_byte);
  assign dig_ok = dig[4];
  assign in_esc = (mode == M_ESC);

  nced_acc u_acc (
    .acc   (acc),
    .digit (dig[3:0]),
    .hex   (hex || in_esc),
    .sum   (sum)
  );

  // saturate at the cap once past the top code point
  assign ent_acc = (acc > CODE_MAX || sum > SUM_W'(CODE_MAX)) ? CODE_CAP : sum[CODE_W-1:0];
  assign esc_val = sum[7:0];

  assign cp            = (acc > CODE_MAX) ? CODE_REPL : acc;
  assign utf_n1        = utf8_last(cp);
  assign utf_last_byte = (idx[1:0] == utf_n1);

  assign ref_len_m1    = REF_IDX_W'(1) + REF_IDX_W'(hex) + REF_IDX_W'(cnt);
  assign ref_last_byte = (idx == ref_len_m1);
  assign held_rd       = idx - REF_IDX_W'(2) - REF_IDX_W'(hex);

  always_comb begin
    if (idx == REF_IDX_W'(0)) begin
      ref_byte = CH_AMP;
    end else if (idx == REF_IDX_W'(1)) begin
      ref_byte = CH_HASH;
    end else if (hex && idx == REF_IDX_W'(2)) begin
      ref_byte = CH_X;
    end else begin
      ref_byte = held[held_rd[HELD_IDX_W-1:0]];
    end
  end

  assign x_start  = (mode == M_HASH) && (cur_byte == CH_X);
  assign dig_take = dig_ok && (cnt < CNT_W'(MAX_DIGITS));
  assign semi_end = (cur_byte == CH_SEMI) && (cnt != '0);
  assign after    = cur_eot ? S_POST : S_DONE;

  // next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      S_IDLE: begin
        if (accept) seq_next = S_HANDLE;
      end
      S_HANDLE: begin
        unique case (mode)
          M_AMP:    seq_next = (cur_byte == CH_HASH) ? after : S_SCAN;
          M_HASH, M_DIGITS: begin
            if (x_start || dig_take) seq_next = after;
            else if (semi_end)       seq_next = S_UTF;
            else                     seq_next = S_REF;
          end
          M_ESC:    seq_next = dig_ok ? after : S_SCAN;
          default:  seq_next = S_SCAN;
        endcase
      end
      S_REF: begin
        if (ref_last_byte) seq_next = rescan ? S_SCAN : S_DONE;
      end
      S_UTF: begin
        if (utf_last_byte) seq_next = after;
      end
      S_SCAN: seq_next = after;
      S_POST: begin
        if (mode == M_HASH || mode == M_DIGITS) seq_next = S_REF;
        else                                    seq_next = S_DONE;
      end
      S_DONE: seq_next = S_IDLE;
      default: seq_next = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req           = '0;
    mode_next     = mode;
    hex_next      = hex;
    acc_next      = acc;
    cnt_next      = cnt;
    esc_one_next  = esc_one;
    rescan_next   = rescan;
    idx_next      = idx;
    cur_byte_next = cur_byte;
    cur_eot_next  = cur_eot;
    held_we       = 1'b0;
    unique case (seq)
      S_IDLE: begin
        if (accept) begin
          cur_byte_next = in_byte;
          cur_eot_next  = in_eot;
        end
      end
      S_HANDLE: begin
        unique case (mode)
          M_AMP: begin
            if (cur_byte == CH_HASH) begin
              mode_next = M_HASH;
            end else begin
              req.push  = 1'b1;
              req.data  = CH_AMP;
              mode_next = M_IDLE;
            end
          end
          M_HASH, M_DIGITS: begin
            mode_next = M_DIGITS;
            if (x_start) begin
              hex_next = 1'b1;
            end else if (dig_take) begin
              held_we  = 1'b1;
              cnt_next = cnt + CNT_W'(1);
              acc_next = ent_acc;
            end else if (semi_end) begin
              idx_next = '0;
            end else begin
              idx_next    = '0;
              rescan_next = 1'b1;
            end
          end
          M_ESC: begin
            if (dig_ok && !esc_one) begin
              acc_next     = CODE_W'(esc_val);
              esc_one_next = 1'b1;
            end else begin
              // second digit completes the byte; a non-digit gives back one digit
              req.push     = esc_one;
              req.data     = dig_ok ? esc_val : acc[7:0];
              mode_next    = M_IDLE;
              acc_next     = '0;
              esc_one_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
      S_REF: begin
        req.push = 1'b1;
        req.data = ref_byte;
        if (ref_last_byte) begin
          mode_next = M_IDLE;
          hex_next  = 1'b0;
          acc_next  = '0;
          cnt_next  = '0;
        end else begin
          idx_next = idx + REF_IDX_W'(1);
        end
      end
      S_UTF: begin
        req.push = 1'b1;
        req.data = utf8_byte(cp, utf_n1, idx[1:0]);
        if (utf_last_byte) begin
          mode_next = M_IDLE;
          hex_next  = 1'b0;
          acc_next  = '0;
          cnt_next  = '0;
        end else begin
          idx_next = idx + REF_IDX_W'(1);
        end
      end
      S_SCAN: begin
        rescan_next = 1'b0;
        if (ent_en && cur_byte == CH_AMP) begin
          mode_next = M_AMP;
        end else if (esc_en && cur_byte == CH_BSLASH) begin
          mode_next = M_ESC;
        end else begin
          req.push = 1'b1;
          req.data = cur_byte;
        end
      end
      S_POST: begin
        // end of text flush
        unique case (mode)
          M_AMP: begin
            req.push  = 1'b1;
            req.data  = CH_AMP;
            mode_next = M_IDLE;
          end
          M_HASH, M_DIGITS: begin
            idx_next    = '0;
            rescan_next = 1'b0;
          end
          M_ESC: begin
            req.push     = esc_one;
            req.data     = acc[7:0];
            mode_next    = M_IDLE;
            acc_next     = '0;
            esc_one_next = 1'b0;
          end
          default: ;
        endcase
      end
      S_DONE: begin
        req.finish = 1'b1;
      end
      default: ;
    endcase
  end

  assign stall = (req.push && !sts.push_ok) || (req.finish && !sts.finish_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq     <= S_IDLE;
      mode    <= M_IDLE;
      hex     <= 1'b0;
      acc     <= '0;
      cnt     <= '0;
      esc_one <= 1'b0;
      rescan  <= 1'b0;
      idx     <= '0;
    end else if (!stall) begin
      seq     <= seq_next;
      mode    <= mode_next;
      hex     <= hex_next;
      acc     <= acc_next;
      cnt     <= cnt_next;
      esc_one <= esc_one_next;
      rescan  <= rescan_next;
      idx     <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_byte <= cur_byte_next;
    cur_eot  <= cur_eot_next;
    if (held_we && !stall) begin
      held[cnt[HELD_IDX_W-1:0]] <= cur_byte;
    end
  end

endmodule

// ----- rtl/nced_checker.sv -----
// ----------------------------------------------------------------------------
// nced_checker - port-level checks for the entity decoder
// Watches the streams and the config port of the top level.
// ----------------------------------------------------------------------------
module nced_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // a stalled output byte holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output byte changed while stalled");

  // input ready is low in the cycle after a request is accepted
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a request");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // entity enable reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
      |-> prdata[0] == $past(pwdata[0]))
    else $error("config readback mismatch");

endmodule

bind numeric_entity_and_escape_decoder nced_checker u_nced_checker (.*);

// ----- sim/numeric_entity_and_escape_decoder_test.sv -----
// ----------------------------------------------------------------------------
// numeric_entity_and_escape_decoder_test - self-checking bench for the decoder
// Streams text bytes into the decoder and predicts every output byte with a
// behavioral decoder of its own: plain text, decimal and hex references,
// backslash escapes, malformed input, end of text flushes and the two enable
// registers. Both stream sides idle and stall at random, and the receiver
// holds off long enough once to fill the block.
// ----------------------------------------------------------------------------
module numeric_entity_and_escape_decoder_test;
  import nced_pkg::*;

  localparam int          HALF_PERIOD  = 10;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 400;
  localparam logic [2:0]  ADDR_ENTITY  = {REG_ENTITY, 2'b00};
  localparam logic [2:0]  ADDR_ESCAPE  = {REG_ESCAPE, 2'b00};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // expected decoded text, oldest byte first
  text_byte_t expected_text[$];
  text_byte_t step_bytes[$];
  text_byte_t oldest;

  // shadow decoder state
  mode_t      ref_mode;
  bit         hex_ref;
  logic [31:0] code_acc;
  logic [7:0] digit_text[MAX_DIGITS];
  int         digit_count;
  int         esc_digits;
  bit         entity_on;
  bit         escape_on;

  int mismatches;
  int requests_sent;
  int bytes_checked;
  bit calm;       // no idling on either side
  bit hold_req;   // asks the receiver for one long hold-off

  numeric_entity_and_escape_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // behavioral decoder
  // --------------------------------------------------------------------------

  // value of a digit character, A-F count in decimal references too
  function automatic int hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    return -1;
  endfunction

  function automatic void put_out(input logic [7:0] b);
    step_bytes.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void put_code_point(input logic [31:0] cp);
    if (cp > 32'h10FFFF) cp = 32'hFFFD;
    if (cp < 32'h80) begin
      put_out(cp[7:0]);
    end else if (cp < 32'h800) begin
      put_out({3'b110, cp[10:6]});
      put_out({2'b10, cp[5:0]});
    end else if (cp < 32'h10000) begin
      put_out({4'b1110, cp[15:12]});
      put_out({2'b10, cp[11:6]});
      put_out({2'b10, cp[5:0]});
    end else begin
      put_out({5'b11110, cp[20:18]});
      put_out({2'b10, cp[17:12]});
      put_out({2'b10, cp[11:6]});
      put_out({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void clear_parse();
    ref_mode    = M_IDLE;
    hex_ref     = 1'b0;
    code_acc    = '0;
    digit_count = 0;
    esc_digits  = 0;
  endfunction

  // a broken reference comes back as the text that was held
  function automatic void dump_reference_text();
    put_out(CH_AMP);
    put_out(CH_HASH);
    if (hex_ref) put_out(CH_X);
    for (int i = 0; i < digit_count; i++) put_out(digit_text[i]);
    clear_parse();
  endfunction

  function automatic void scan_text_byte(input logic [7:0] b);
    if (entity_on && b == CH_AMP) begin
      clear_parse();
      ref_mode = M_AMP;
    end else if (escape_on && b == CH_BSLASH) begin
      clear_parse();
      ref_mode = M_ESC;
    end else begin
      put_out(b);
    end
  endfunction

  function automatic void reference_digit(input logic [7:0] b);
    int d;
    d = hex_value(b);
    if (d >= 0 && digit_count < MAX_DIGITS) begin
      digit_text[digit_count] = b;
      digit_count++;
      // saturates once past the last code point
      if (code_acc > 32'h10FFFF) begin
        code_acc = 32'h110000;
      end else begin
        code_acc = code_acc * (hex_ref ? 16 : 10) + d;
        if (code_acc > 32'h10FFFF) code_acc = 32'h110000;
      end
    end else if (d < 0 && b == CH_SEMI && digit_count > 0) begin
      put_code_point(code_acc);
      clear_parse();
    end else begin
      dump_reference_text();
      scan_text_byte(b);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    int d;
    case (ref_mode)
      M_AMP: begin
        if (b == CH_HASH) begin
          clear_parse();
          ref_mode = M_HASH;
        end else begin
          put_out(CH_AMP);
          clear_parse();
          scan_text_byte(b);
        end
      end
      M_HASH: begin
        ref_mode = M_DIGITS;
        if (b == CH_X) hex_ref = 1'b1;
        else reference_digit(b);
      end
      M_DIGITS: reference_digit(b);
      M_ESC: begin
        d = hex_value(b);
        if (d >= 0) begin
          code_acc = ((code_acc << 4) | d) & 32'hFF;
          esc_digits++;
          if (esc_digits >= 2) begin
            put_out(code_acc[7:0]);
            clear_parse();
          end
        end else begin
          // lone backslash is dropped, one digit still makes a byte
          if (esc_digits == 1) put_out(code_acc[7:0]);
          clear_parse();
          scan_text_byte(b);
        end
      end
      default: begin
        clear_parse();
        scan_text_byte(b);
      end
    endcase
  endfunction

  function automatic void flush_at_end();
    case (ref_mode)
      M_AMP:            put_out(CH_AMP);
      M_HASH, M_DIGITS: dump_reference_text();
      M_ESC:            if (esc_digits == 1) put_out(code_acc[7:0]);
      default:          ;
    endcase
    clear_parse();
  endfunction

  // expected output bytes of one accepted request
  function automatic void predict_request(input logic [7:0] b, input logic eot);
    step_bytes.delete();
    decode_byte(b);
    if (eot) flush_at_end();
    if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
    foreach (step_bytes[i]) expected_text.push_back(step_bytes[i]);
  endfunction

  // --------------------------------------------------------------------------
  // output side: stall pattern and checking
  // --------------------------------------------------------------------------

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the block backs up into its input
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      bytes_checked++;
      if (expected_text.size() == 0) begin
        $error("out_byte with nothing expected: actual %h", m_tdata);
        mismatches++;
      end else begin
        oldest = expected_text.pop_front();
        if (m_tdata !== oldest.data) begin
          $error("out_byte expected %h actual %h", oldest.data, m_tdata);
          mismatches++;
        end
        if (m_tlast !== oldest.last) begin
          $error("run_last expected %b actual %b", oldest.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side and config port; every task starts and ends at a falling edge
  // --------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = eot;
    do @(posedge clk); while (!s_tready);
    predict_request(b, eot);
    requests_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_text(input string s, input bit eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
  endtask

  // wait for the expected text to drain and the block to go quiet
  task automatic settle();
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // write one enable, then read it back in the next transfer
  task automatic write_register(input logic [2:0] addr, input bit value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {31'b0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ENTITY) entity_on = value;
    else escape_on = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, value}) begin
      $error("prdata at %h expected %h actual %h", addr, {31'b0, value}, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [7:0] pick_digit(input bit hex);
    int v;
    v = $urandom_range(0, hex ? 15 : 9);
    if (!hex && $urandom_range(0, 7) == 0) v = $urandom_range(10, 15);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (hex_value(b) >= 0) b = "z";
    return b;
  endfunction

  // mostly well-formed references and escapes with random content,
  // the rest plain noise and broken sequences
  task automatic send_random_fragment();
    logic [7:0] frag[$];
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      repeat ($urandom_range(1, 4)) frag.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 45) begin
      frag = '{CH_AMP, CH_HASH};
      repeat ($urandom_range(1, 7)) frag.push_back(pick_digit(1'b0));
      frag.push_back(CH_SEMI);
    end else if (kind < 65) begin
      frag = '{CH_AMP, CH_HASH, CH_X};
      repeat ($urandom_range(1, 6)) frag.push_back(pick_digit(1'b1));
      frag.push_back(CH_SEMI);
    end else if (kind < 78) begin
      frag = '{CH_BSLASH, pick_digit(1'b1), pick_digit(1'b1)};
    end else if (kind < 84) begin
      frag = '{CH_BSLASH, pick_digit(1'b1), pick_non_hex()};
    end else if (kind < 95) begin
      case ($urandom_range(0, 3))
        0: frag = '{CH_AMP, 8'($urandom_range(0, 255))};
        1: frag = '{CH_AMP, CH_HASH, "X", pick_digit(1'b1)};
        2: frag = '{CH_AMP, CH_HASH, CH_SEMI};
        default: begin
          frag = '{CH_AMP, CH_HASH};
          if ($urandom_range(0, 1)) frag.push_back(CH_X);
          repeat ($urandom_range(0, 4)) frag.push_back(pick_digit(1'b1));
          frag.push_back(pick_non_hex());
        end
      endcase
    end else begin
      // one below the digit limit, at it, or one past it
      frag = '{CH_AMP, CH_HASH};
      if ($urandom_range(0, 1)) frag.push_back(CH_X);
      n = $urandom_range(MAX_DIGITS - 1, MAX_DIGITS + 1);
      repeat (n) frag.push_back(pick_digit(1'b1));
      frag.push_back(CH_SEMI);
    end
    foreach (frag[i]) send_byte(frag[i], i == frag.size() - 1 && $urandom_range(0, 5) == 0);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  task automatic test_plain_text();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("&aX", 1'b1);   // ampersand without hash goes back as text
  endtask

  task automatic test_references();
    send_text("&#0;", 1'b0);         // code zero
    send_text("&#1aF;", 1'b0);       // letters in a decimal reference
    send_text("&#x10FFFF;", 1'b0);   // largest code point, four bytes
    send_text("&#9999999;", 1'b0);   // saturates to the replacement char
    send_text("&#xD800;", 1'b0);     // surrogate encoded as is
  endtask

  task automatic test_malformed();
    send_text("&#X", 1'b0);    // upper-case x is not a hex marker
    send_text("&#;", 1'b0);
    send_text("&#x;", 1'b0);
    send_text("&#12z", 1'b0);
    // one digit past the limit brings back the longest text
    send_text("&#x", 1'b0);
    repeat (MAX_DIGITS + 1) send_byte("f", 1'b0);
    send_text("&#3", 1'b1);    // open reference flushed at end of text
  endtask

  task automatic test_escapes();
    send_text("\\41", 1'b0);
    send_text("\\7q", 1'b0);   // one digit then non-hex
    send_text("\\q", 1'b0);    // backslash dropped
    send_text("\\\\4", 1'b0);
    send_text("\\5", 1'b1);    // one digit flushed at end of text
    send_text("\\", 1'b1);
    send_text("&", 1'b1);
  endtask

  task automatic test_registers();
    settle();
    write_register(ADDR_ENTITY, 1'b0);
    send_text("&#65;\\41", 1'b1);
    settle();
    write_register(ADDR_ESCAPE, 1'b0);
    send_text("&#65;\\41", 1'b1);
    settle();
    write_register(ADDR_ENTITY, 1'b1);
    write_register(ADDR_ESCAPE, 1'b1);
    // a parse under way finishes after its start is disabled
    send_text("&#6\\4", 1'b0);
    send_text("&#6", 1'b0);
    settle();
    write_register(ADDR_ENTITY, 1'b0);
    write_register(ADDR_ESCAPE, 1'b0);
    send_text("5;&\\", 1'b1);
    settle();
    write_register(ADDR_ENTITY, 1'b1);
    write_register(ADDR_ESCAPE, 1'b1);
  endtask

  task automatic test_output_backpressure();
    int start;
    hold_req = 1'b1;
    start = requests_sent;
    while (requests_sent - start < 40) send_random_fragment();
    settle();
  endtask

  task automatic test_random_text(input int count, input bit ent, input bit esc);
    int start;
    settle();
    write_register(ADDR_ENTITY, ent);
    write_register(ADDR_ESCAPE, esc);
    start = requests_sent;
    while (requests_sent - start < count) send_random_fragment();
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    mismatches    = 0;
    requests_sent = 0;
    bytes_checked = 0;
    entity_on     = 1'b1;
    escape_on     = 1'b1;
    clear_parse();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_plain_text();
    test_references();
    test_malformed();
    test_escapes();
    test_registers();
    test_output_backpressure();
    test_random_text(60, 1'b1, 1'b1);
    test_random_text(25, 1'b0, 1'b1);
    test_random_text(25, 1'b1, 1'b0);
    test_random_text(15, 1'b0, 1'b0);
    settle();
    calm = 1'b1;
    test_random_text(30, 1'b1, 1'b1);

    settle();
    $display("sent %0d text bytes, checked %0d decoded bytes", requests_sent, bytes_checked);
    $display("covered references, escapes, malformed input, flushes and all enable settings");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("watchdog expired with %0d bytes outstanding", expected_text.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
